FILE: design/supt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supt_pkg: shared types and constants of the sorted pair table
// Beat layouts of both channels, the cell control group, status and mode
// codes, and the reset values of the minimum registers.
// ----------------------------------------------------------------------------
package supt_pkg;

    // Input beat: one insert or one read request.
    typedef struct packed {
        logic        mode;
        logic [15:0] width;
        logic [15:0] height;
        logic [5:0]  read_index;
    } t_in_beat;

    // Output beat: one result for every accepted input beat.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] entry_width;
        logic [15:0] entry_height;
        logic [6:0]  entry_count;
    } t_out_beat;

    // Sort key: width in the upper half, height in the lower half.
    typedef logic [31:0] t_key;

    // Control group broadcast from the sequencer to every cell.
    typedef struct packed {
        logic       cmp_en;
        logic       upd_en;
        t_key       key;
        logic [5:0] rd_idx;
    } t_cell_ctl;

    // Per-cell compare results handed back to the sequencer.
    typedef struct packed {
        logic lt;
        logic eq;
        t_key rd_key;
    } t_cell_res;

    // Mode codes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // Status codes.
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_BELOW    = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_READ_OK  = 3'd4;
    localparam logic [2:0] ST_RANGE    = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_MIN_WIDTH  = 1'b0;
    localparam logic CFG_MIN_HEIGHT = 1'b1;

    // Reset values of the minimum registers.
    localparam logic [15:0] MIN_WIDTH_RST  = 16'd640;
    localparam logic [15:0] MIN_HEIGHT_RST = 16'd480;

endpackage

FILE: design/supt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supt_cell: one slot of the sorted pair table
// Holds one key, compares it against the broadcast key, and on an insert
// keeps its key, takes the new key, or takes its left neighbor's key.
// ----------------------------------------------------------------------------
module supt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  supt_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]       i_count,
    input  supt_pkg::t_key      i_left_key,
    input  logic                i_left_lt,
    output supt_pkg::t_key      o_key,
    output supt_pkg::t_cell_res o_res
);
    import supt_pkg::*;

    t_key r_key;
    logic r_lt;
    logic r_eq;
    t_key r_rd_key;
    logic w_valid;
    logic w_sel;

    // The slot holds a live entry when its position is below the count.
    assign w_valid = (IDX < int'(i_count));
    assign w_sel   = (int'(i_ctl.rd_idx) == IDX);

    // Compare step: flags and read data are registered for the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_lt <= w_valid && (r_key < i_ctl.key);
            r_eq <= w_valid && (r_key == i_ctl.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_rd_key <= w_sel ? r_key : '0;
        end
    end

    // Insert step: smaller entries stay, the first larger slot takes the new
    // key, and every slot above it takes its left neighbor's key.
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd_en && !r_lt) begin
            r_key <= i_left_lt ? i_ctl.key : i_left_key;
        end
    end

    assign o_key        = r_key;
    assign o_res.lt     = r_lt;
    assign o_res.eq     = r_eq;
    assign o_res.rd_key = r_rd_key;

endmodule

FILE: design/sorted_unique_pair_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_pair_table_unit: bounded sorted set of (width, height) pairs
// Inserts distinct pairs at their sorted place in a row of cells and reads
// entries back by ordinal position; every beat returns one result.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_stall    i_in_beat  (t_in_beat)
//  out       output     o_out_valid / i_out_stall  o_out_beat (t_out_beat)
//  cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
//  An item goes through accept, compare in every cell, then update.
//  The update cycle waits while a previous result is still held on the output.
//  Input beats are taken only while the sequencer is idle.
//  Reset (synchronous, active low) empties the table and restores the minimums.
// ----------------------------------------------------------------------------
module sorted_unique_pair_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  supt_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output supt_pkg::t_out_beat o_out_beat,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import supt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    t_in_beat      r_item;
    logic [CW-1:0] r_count;
    logic [15:0]   r_min_width;
    logic [15:0]   r_min_height;
    logic          r_out_valid;
    t_out_beat     r_out_beat;
    t_out_beat     n_out_beat;

    t_cell_ctl     w_ctl;
    t_key          w_key     [TABLE_DEPTH];
    t_cell_res     w_res     [TABLE_DEPTH];
    logic          w_in_acc;
    logic          w_out_free;
    logic          w_finish;
    logic          w_do_insert;
    logic          w_dup;
    t_key          w_rd_key;
    logic [CW-1:0] n_count;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == S_UPD) && w_out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width  <= MIN_WIDTH_RST;
            r_min_height <= MIN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_WIDTH:  r_min_width  <= i_cfg_data;
                CFG_MIN_HEIGHT: r_min_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_beat;
        end
    end

    // Control broadcast to the row of cells.
    always_comb begin
        w_ctl.cmp_en = (r_state == S_CMP);
        w_ctl.upd_en = w_finish && w_do_insert;
        w_ctl.key    = {r_item.width, r_item.height};
        w_ctl.rd_idx = r_item.read_index;
    end

    // Row of cells; each takes the left neighbor's key on an insert.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            supt_cell #(.IDX(g), .CW(CW)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_count    (r_count),
                .i_left_key (w_ctl.key),
                .i_left_lt  (1'b1),
                .o_key      (w_key[g]),
                .o_res      (w_res[g])
            );
        end else begin : g_next
            supt_cell #(.IDX(g), .CW(CW)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_count    (r_count),
                .i_left_key (w_key[g-1]),
                .i_left_lt  (w_res[g-1].lt),
                .o_key      (w_key[g]),
                .o_res      (w_res[g])
            );
        end
    end

    // Gather duplicate flags and the selected read entry.
    always_comb begin
        w_dup    = 1'b0;
        w_rd_key = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_dup    = w_dup | w_res[i].eq;
            w_rd_key = w_rd_key | w_res[i].rd_key;
        end
    end

    // Result of the item in the update cycle.
    always_comb begin
        w_do_insert             = 1'b0;
        n_count                 = r_count;
        n_out_beat.entry_width  = '0;
        n_out_beat.entry_height = '0;
        if (r_item.mode == MODE_READ) begin
            if (int'(r_item.read_index) < int'(r_count)) begin
                n_out_beat.status       = ST_READ_OK;
                n_out_beat.entry_width  = w_rd_key[31:16];
                n_out_beat.entry_height = w_rd_key[15:0];
            end else begin
                n_out_beat.status = ST_RANGE;
            end
        end else if (r_item.width < r_min_width || r_item.height < r_min_height) begin
            n_out_beat.status = ST_BELOW;
        end else if (w_dup) begin
            n_out_beat.status = ST_DUP;
        end else if (int'(r_count) >= TABLE_DEPTH) begin
            n_out_beat.status = ST_FULL;
        end else begin
            n_out_beat.status = ST_INSERTED;
            w_do_insert       = 1'b1;
            n_count           = r_count + CW'(1);
        end
        n_out_beat.entry_count = 7'(n_count);
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_finish) begin
            r_count <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted unique pair table
// Offers insert and read beats with random gaps and output stalls. A local
// copy of the sorted table predicts each result beat, and the bench compares
// every field in order. The run first covers the boundary and special cases,
// then runs random phases under several minimum settings, and holds the
// output off for a long stretch so that the table stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import supt_pkg::*;

    localparam int DEPTH         = 64;
    localparam int DRAIN_CYCLES  = 6;
    localparam int PRESSURE_HOLD = 300;
    localparam int TIMEOUT_NS    = 3000000;

    // Ports of the block.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_beat   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_beat;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_index = CFG_MIN_WIDTH;
    logic [15:0] i_cfg_data = '0;

    // Local copy of the table and of its minimum registers.
    t_key        sorted_keys [DEPTH];
    int          key_count = 0;
    logic [15:0] lim_w = MIN_WIDTH_RST;
    logic [15:0] lim_h = MIN_HEIGHT_RST;

    // Beats waiting to be offered, and result beats still owed by the block.
    t_in_beat  queued_requests [$];
    t_out_beat table_answers [$];
    t_key      offered_keys [$];

    // Bench control and bookkeeping.
    bit in_taken     = 1'b0;
    bit send_gaps    = 1'b1;
    bit recv_gaps    = 1'b1;
    int send_wait    = 0;
    int hold_left    = 0;
    int pressure_ask = 0;
    int pressure_seen = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int status_hits [6];

    sorted_unique_pair_table_unit #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Applies one beat to the local table and returns the result it owes.
    function automatic t_out_beat table_response(input t_in_beat b);
        t_out_beat r;
        t_key      key;
        int        pos;
        int        i;
        bit        dup;
        r = '0;
        if (b.mode == MODE_READ) begin
            if (int'(b.read_index) < key_count) begin
                r.status       = ST_READ_OK;
                r.entry_width  = sorted_keys[b.read_index][31:16];
                r.entry_height = sorted_keys[b.read_index][15:0];
            end else begin
                r.status = ST_RANGE;
            end
        end else if (b.width < lim_w || b.height < lim_h) begin
            r.status = ST_BELOW;
        end else begin
            key = {b.width, b.height};
            pos = 0;
            dup = 1'b0;
            for (i = 0; i < key_count; i++) begin
                if (sorted_keys[i] == key)
                    dup = 1'b1;
                else if (sorted_keys[i] < key)
                    pos = i + 1;
            end
            if (dup) begin
                r.status = ST_DUP;
            end else if (key_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // Larger entries move up by one to open the sorted slot.
                for (i = key_count; i > pos; i--)
                    sorted_keys[i] = sorted_keys[i - 1];
                sorted_keys[pos] = key;
                key_count++;
                r.status = ST_INSERTED;
            end
        end
        r.entry_count = 7'(key_count);
        return r;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Input driver: a new beat goes out at a falling edge once the last one
    // was taken and any random gap has run out; a stalled beat stays as it is.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_wait != 0) begin
                send_wait = send_wait - 1;
                i_in_valid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
                i_in_beat  <= queued_requests.pop_front();
                i_in_valid <= 1'b1;
                send_wait  = send_gaps ? gap_cycles() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall driver: random holds, plus one long hold on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (pressure_seen != pressure_ask) begin
                pressure_seen = pressure_ask;
                hold_left     = PRESSURE_HOLD;
            end else if (hold_left == 0 && recv_gaps && $urandom_range(0, 99) >= 70) begin
                hold_left = gap_cycles() + 1;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Monitor: checks result beats against the oldest prediction, then
    // predicts the result of any input beat taken at this edge.
    always @(posedge i_clk) begin
        t_out_beat want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                results_seen++;
                if (o_out_beat.status < 6)
                    status_hits[o_out_beat.status]++;
                if (table_answers.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected beat %0d/%0d/%0d/%0d",
                                 $realtime, o_out_beat.status, o_out_beat.entry_width,
                                 o_out_beat.entry_height, o_out_beat.entry_count);
                end else begin
                    want = table_answers.pop_front();
                    if (o_out_beat.status !== want.status ||
                        o_out_beat.entry_width !== want.entry_width ||
                        o_out_beat.entry_height !== want.entry_height ||
                        o_out_beat.entry_count !== want.entry_count) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     $realtime, want.status, want.entry_width,
                                     want.entry_height, want.entry_count,
                                     o_out_beat.status, o_out_beat.entry_width,
                                     o_out_beat.entry_height, o_out_beat.entry_count);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                table_answers.push_back(table_response(i_in_beat));
            end
        end
    end

    // Queues an insert beat; the read index carries random junk.
    task automatic offer_pair(input logic [15:0] w, input logic [15:0] h);
        t_in_beat b;
        b.mode       = MODE_INSERT;
        b.width      = w;
        b.height     = h;
        b.read_index = 6'($urandom_range(0, 63));
        queued_requests.push_back(b);
        offered_keys.push_back({w, h});
    endtask

    // Queues a read beat; the pair fields carry random junk.
    task automatic offer_read(input int idx);
        t_in_beat b;
        b.mode       = MODE_READ;
        b.width      = 16'($urandom_range(0, 65535));
        b.height     = 16'($urandom_range(0, 65535));
        b.read_index = 6'(idx);
        queued_requests.push_back(b);
    endtask

    // Waits until every queued beat is out and every result has returned.
    task automatic wait_drained();
        while (queued_requests.size() != 0 || i_in_valid || table_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes one minimum register while the table is idle.
    task automatic write_limit(input logic idx, input logic [15:0] val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_MIN_WIDTH)
            lim_w = val;
        else
            lim_h = val;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random beats: reads, repeats of earlier pairs, pairs below a minimum,
    // pairs sharing an earlier width, and fresh pairs above the minimums.
    task automatic offer_random(input int count, input int read_pct);
        int          n;
        int          r;
        t_key        k;
        logic [15:0] w;
        logic [15:0] h;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < read_pct) begin
                offer_read($urandom_range(0, 63));
            end else begin
                if (r < 15 && offered_keys.size() != 0) begin
                    k = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
                    w = k[31:16];
                    h = k[15:0];
                end else if (r < 27) begin
                    w = 16'($urandom_range(0, 65535));
                    h = 16'($urandom_range(0, 65535));
                    if (lim_w != 0 && (r % 2) == 1)
                        w = 16'($urandom_range(0, lim_w - 1));
                    else if (lim_h != 0)
                        h = 16'($urandom_range(0, lim_h - 1));
                end else if (r < 45 && offered_keys.size() != 0) begin
                    k = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
                    w = k[31:16];
                    h = 16'($urandom_range(lim_h, 65535));
                end else begin
                    w = 16'($urandom_range(lim_w, 65535));
                    h = 16'($urandom_range(lim_h, 65535));
                end
                offer_pair(w, h);
            end
        end
    endtask

    // Main sequence: reset, directed cases, then random phases.
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, the reset minimums, sorting within one width.
        offer_read(0);
        offer_read(63);
        offer_pair(16'd639, 16'd480);
        offer_pair(16'd640, 16'd479);
        offer_pair(16'd0, 16'd0);
        offer_pair(16'd640, 16'd480);
        offer_pair(16'hFFFF, 16'hFFFF);
        offer_pair(16'd640, 16'd480);
        offer_pair(16'd640, 16'hFFFF);
        offer_pair(16'hFFFF, 16'd480);
        offer_pair(16'd1000, 16'd600);
        offer_read(0);
        offer_read(1);
        offer_read(4);
        offer_read(5);
        offer_read(63);

        // Both minimums at zero.
        write_limit(CFG_MIN_WIDTH, 16'd0);
        write_limit(CFG_MIN_HEIGHT, 16'd0);
        offer_pair(16'd0, 16'd0);
        offer_pair(16'd0, 16'hFFFF);
        offer_pair(16'hFFFF, 16'd0);
        offer_read(0);

        // Both minimums at the top: the minimum check comes before the
        // duplicate check.
        write_limit(CFG_MIN_WIDTH, 16'hFFFF);
        write_limit(CFG_MIN_HEIGHT, 16'hFFFF);
        offer_pair(16'hFFFF, 16'hFFFF);
        offer_pair(16'd640, 16'd480);
        offer_pair(16'hFFFE, 16'hFFFF);
        offer_pair(16'hFFFF, 16'hFFFE);
        offer_read(7);
        offer_read(8);

        // Low random minimums: the table fills up here.
        write_limit(CFG_MIN_WIDTH, 16'($urandom_range(0, 2000)));
        write_limit(CFG_MIN_HEIGHT, 16'($urandom_range(0, 2000)));
        offer_random(350, 45);

        // Top minimums, no idling on the input, and one long output hold.
        write_limit(CFG_MIN_WIDTH, 16'hFFFF);
        write_limit(CFG_MIN_HEIGHT, 16'hFFFF);
        wait_drained();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        offer_random(250, 40);
        pressure_ask++;
        wait_drained();
        send_gaps = 1'b1;
        recv_gaps = 1'b1;

        // Full-range random minimums.
        write_limit(CFG_MIN_WIDTH, 16'($urandom_range(0, 65535)));
        write_limit(CFG_MIN_HEIGHT, 16'($urandom_range(0, 65535)));
        offer_random(250, 40);

        // Zero minimums: every fresh pair meets a full table.
        write_limit(CFG_MIN_WIDTH, 16'd0);
        write_limit(CFG_MIN_HEIGHT, 16'd0);
        offer_random(250, 40);

        // Back to the reset values.
        write_limit(CFG_MIN_WIDTH, MIN_WIDTH_RST);
        write_limit(CFG_MIN_HEIGHT, MIN_HEIGHT_RST);
        offer_random(330, 40);

        wait_drained();
        $display("checked %0d result beats over %0d register writes; %0d mismatches",
                 results_seen, cfg_writes, mismatch_count);
        $display("inserted %0d, below %0d, duplicate %0d, full %0d, read %0d, out of range %0d",
                 status_hits[ST_INSERTED], status_hits[ST_BELOW], status_hits[ST_DUP],
                 status_hits[ST_FULL], status_hits[ST_READ_OK], status_hits[ST_RANGE]);
        if (mismatch_count == 0 && table_answers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d result beats outstanding", table_answers.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sorted_unique_pair_table_unit.f
design/supt_pkg.sv
design/supt_cell.sv
design/sorted_unique_pair_table_unit.sv
bench/tb.sv
